// ----- src/lruk_pkg.sv -----
package lruk_pkg;

    // request kinds
    typedef enum logic [2:0] {
        FUNC_ACCESS = 3'd0,
        FUNC_SET    = 3'd1,
        FUNC_REMOVE = 3'd2,
        FUNC_EVICT  = 3'd3,
        FUNC_SIZE   = 3'd4
    } func_t;

    // result error codes
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_RANGE  = 2'd1;
    localparam logic [1:0] ERR_PINNED = 2'd2;

    // configuration register indexes
    localparam logic [0:0] CFG_FRAMES = 1'd0;
    localparam logic [0:0] CFG_DEPTH  = 1'd1;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SHIFT = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_CMP   = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

endpackage

// ----- src/lruk_cmp.sv -----
// Stamp comparator with running-minimum registers for one class.
module lruk_cmp #(
    parameter int STAMP_BITS = 32,
    parameter int FW         = 6
) (
    input  logic                  aclk,
    input  logic                  clr,
    input  logic                  en,
    input  logic [STAMP_BITS-1:0] stamp,
    input  logic [FW-1:0]         frame,
    output logic                  found,
    output logic [FW-1:0]         best_frame
);
    logic                  found_reg;
    logic [STAMP_BITS-1:0] best_ts_reg;
    logic [FW-1:0]         best_f_reg;

    // strict less keeps the lowest frame on ties (frames scanned ascending)
    always_ff @(posedge aclk) begin
        if (clr) begin
            found_reg <= 1'b0;
        end else if (en && (!found_reg || stamp < best_ts_reg)) begin
            found_reg   <= 1'b1;
            best_ts_reg <= stamp;
            best_f_reg  <= frame;
        end
    end

    assign found      = found_reg;
    assign best_frame = best_f_reg;
endmodule

// ----- src/lru_k_replacement_policy.sv -----
// LRU-K victim chooser. Each beat takes one request and returns one result.
// Access shifts the frame's stamp history one slot at a time (a read phase
// then a write phase per slot, with the new stamp written into slot 0),
// evict reads each frame's stamp in a scan state and compares it in a compare
// state, and other requests go straight to the result.
// The block takes no new request until the result beat has been accepted,
// and a register write in the same cycle as a request is taken first.
// Stamp memory needs no clearing pass.
module lru_k_replacement_policy #(
    parameter int FRAMES     = 64,
    parameter int K_MAX      = 8,
    parameter int STAMP_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [6:0]            cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_func,
    input  logic [5:0]            s_frame,
    input  logic                  s_evictable_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_victim_valid,
    output logic [5:0]            m_victim_frame,
    output logic [6:0]            m_evictable_count,
    output logic [1:0]            m_error_code
);
    import lruk_pkg::*;

    localparam int FW  = $clog2(FRAMES);
    localparam int KW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int KCW = $clog2(K_MAX + 1);
    localparam int CW  = $clog2(FRAMES + 1);
    localparam int AW  = FW + KW;
    localparam logic [STAMP_BITS-1:0] SMAX = '1;

    state_t state_reg;
    logic [6:0] fiu_reg;
    logic [3:0] hd_reg;
    logic [FRAMES-1:0] pres_reg, evb_reg;
    logic [KCW-1:0] fill_reg [FRAMES];
    logic [STAMP_BITS-1:0] clk_reg;
    logic [CW-1:0] tot_reg;
    logic [2:0] func_reg;
    logic [FW-1:0] frame_reg;
    logic val_reg, rng_reg;
    logic [KW:0] slot_reg;
    logic [FW:0] scan_reg;
    logic [KCW-1:0] k_reg;
    logic sfull_reg, svalid_reg;
    logic [FW-1:0] sframe_reg;
    logic r_vv_reg;
    logic [5:0] r_vf_reg;
    logic [1:0] r_err_reg;
    // shift phase: 0 reads slot-1, 1 writes it into slot
    logic shw_reg;

    // stamp memory
    logic [STAMP_BITS-1:0] mem [FRAMES*K_MAX];
    logic [STAMP_BITS-1:0] rd_data_reg;
    logic we, re;
    logic [AW-1:0] waddr, raddr;
    logic [STAMP_BITS-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rd_data_reg <= mem[raddr];
    end

    // effective K, clamped
    logic [KCW-1:0] k_eff;
    always_comb begin
        if (hd_reg == 4'd0) k_eff = KCW'(1);
        else if (32'(hd_reg) > K_MAX) k_eff = KCW'(K_MAX);
        else k_eff = KCW'(hd_reg);
    end

    logic in_rng;
    assign in_rng = ({1'b0, s_frame} < ((32'(fiu_reg) < FRAMES) ? 7'(fiu_reg)
                     : 7'(FRAMES))) && (32'(s_frame) < FRAMES);

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_valid   = (state_reg == ST_OUT);

    // scanned frame's slot selection
    logic [FW-1:0] scan_f;
    logic [KCW-1:0] sfill;
    logic scand, sfull;
    logic [KW-1:0] sslot;
    assign scan_f = scan_reg[FW-1:0];
    assign sfill  = fill_reg[scan_f];
    assign scand  = pres_reg[scan_f] && evb_reg[scan_f];
    assign sfull  = sfill >= k_reg;
    always_comb begin
        if (sfull) sslot = KW'(k_reg - KCW'(1));
        else if (sfill != '0) sslot = KW'(sfill - KCW'(1));
        else sslot = '0;
    end

    logic cmp_clr, inf_found, fin_found;
    logic [FW-1:0] inf_f, fin_f;
    lruk_cmp #(.STAMP_BITS(STAMP_BITS), .FW(FW)) u_inf (
        .aclk(aclk), .clr(cmp_clr),
        .en(state_reg == ST_CMP && svalid_reg && !sfull_reg),
        .stamp(rd_data_reg), .frame(sframe_reg),
        .found(inf_found), .best_frame(inf_f));
    lruk_cmp #(.STAMP_BITS(STAMP_BITS), .FW(FW)) u_fin (
        .aclk(aclk), .clr(cmp_clr),
        .en(state_reg == ST_CMP && svalid_reg && sfull_reg),
        .stamp(rd_data_reg), .frame(sframe_reg),
        .found(fin_found), .best_frame(fin_f));

    // memory port control
    always_comb begin
        we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = rd_data_reg;
        cmp_clr = (state_reg == ST_IDLE);
        if (state_reg == ST_SHIFT) begin
            // slot_reg counts down: first phase reads slot-1, second writes slot
            if (slot_reg == '0) begin
                we = 1'b1; waddr = {frame_reg, KW'(0)}; wdata = clk_reg;
            end else if (shw_reg) begin
                we = 1'b1; waddr = {frame_reg, KW'(slot_reg)};
            end else begin
                re = 1'b1; raddr = {frame_reg, KW'(slot_reg - 1'b1)};
            end
        end
        if (state_reg == ST_SCAN) begin
            re = 1'b1; raddr = {scan_f, sslot};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fiu_reg   <= 7'd64;
            hd_reg    <= 4'd2;
            pres_reg  <= '0;
            evb_reg   <= '0;
            clk_reg   <= '0;
            tot_reg   <= '0;
            shw_reg   <= 1'b0;
            for (int i = 0; i < FRAMES; i++) fill_reg[i] <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) begin
                        if (cfg_index == CFG_FRAMES) fiu_reg <= cfg_data;
                        else hd_reg <= cfg_data[3:0];
                    end else if (s_valid) begin
                        func_reg  <= s_func;
                        frame_reg <= s_frame[FW-1:0];
                        val_reg   <= s_evictable_value;
                        rng_reg   <= in_rng;
                        k_reg     <= k_eff;
                        slot_reg  <= (KW+1)'(K_MAX - 1);
                        scan_reg  <= '0;
                        svalid_reg <= 1'b0;
                        shw_reg   <= 1'b0;
                        state_reg <= ST_DONE;
                        if (s_func == FUNC_ACCESS && in_rng) state_reg <= ST_SHIFT;
                        if (s_func == FUNC_EVICT) state_reg <= ST_SCAN;
                    end
                end
                ST_SHIFT: begin
                    // read slot-1 then write it into slot, one phase each
                    if (slot_reg == '0) begin
                        state_reg <= ST_DONE;
                    end else if (!shw_reg) begin
                        shw_reg <= 1'b1;
                    end else begin
                        shw_reg  <= 1'b0;
                        slot_reg <= slot_reg - 1'b1;
                    end
                end
                ST_SCAN: begin
                    sframe_reg <= scan_f;
                    sfull_reg  <= sfull;
                    svalid_reg <= scand;
                    scan_reg   <= scan_reg + 1'b1;
                    state_reg  <= ST_CMP;
                end
                ST_CMP: begin
                    if (32'(scan_reg) == FRAMES) state_reg <= ST_DONE;
                    else state_reg <= ST_SCAN;
                end
                ST_DONE: begin
                    r_vv_reg  <= 1'b0;
                    r_vf_reg  <= '0;
                    r_err_reg <= ERR_OK;
                    state_reg <= ST_OUT;
                    case (func_reg)
                        FUNC_ACCESS: begin
                            if (!rng_reg) begin
                                r_err_reg <= ERR_RANGE;
                            end else begin
                                if (!pres_reg[frame_reg]) begin
                                    pres_reg[frame_reg] <= 1'b1;
                                    evb_reg[frame_reg]  <= 1'b0;
                                    fill_reg[frame_reg] <= KCW'(1);
                                end else if (fill_reg[frame_reg] < k_reg) begin
                                    fill_reg[frame_reg] <= fill_reg[frame_reg] + 1'b1;
                                end else begin
                                    fill_reg[frame_reg] <= k_reg;
                                end
                                if (clk_reg != SMAX) clk_reg <= clk_reg + 1'b1;
                            end
                        end
                        FUNC_SET: begin
                            if (!rng_reg) begin
                                r_err_reg <= ERR_RANGE;
                            end else if (pres_reg[frame_reg]
                                         && evb_reg[frame_reg] != val_reg) begin
                                evb_reg[frame_reg] <= val_reg;
                                if (val_reg) tot_reg <= tot_reg + 1'b1;
                                else if (tot_reg != '0) tot_reg <= tot_reg - 1'b1;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (!rng_reg) begin
                                r_err_reg <= ERR_RANGE;
                            end else if (pres_reg[frame_reg]) begin
                                if (!evb_reg[frame_reg]) begin
                                    r_err_reg <= ERR_PINNED;
                                end else begin
                                    pres_reg[frame_reg] <= 1'b0;
                                    evb_reg[frame_reg]  <= 1'b0;
                                    fill_reg[frame_reg] <= '0;
                                    if (tot_reg != '0) tot_reg <= tot_reg - 1'b1;
                                end
                            end
                        end
                        FUNC_EVICT: begin
                            if (inf_found || fin_found) begin
                                pres_reg[inf_found ? inf_f : fin_f] <= 1'b0;
                                evb_reg[inf_found ? inf_f : fin_f]  <= 1'b0;
                                fill_reg[inf_found ? inf_f : fin_f] <= '0;
                                if (tot_reg != '0) tot_reg <= tot_reg - 1'b1;
                                r_vv_reg <= 1'b1;
                                r_vf_reg <= 6'(inf_found ? inf_f : fin_f);
                            end
                        end
                        default: ;
                    endcase
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_victim_valid    = r_vv_reg;
    assign m_victim_frame    = r_vf_reg;
    assign m_evictable_count = (32'(tot_reg) > 127) ? 7'd127 : 7'(tot_reg);
    assign m_error_code      = r_err_reg;
endmodule
